// File: hw/rtl/vsv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vsv_pkg
// Types, character codes and small lookup functions for the VIN validator.
// ----------------------------------------------------------------------------
package vsv_pkg;

    localparam logic [4:0] VIN_LEN      = 5'd17;
    localparam logic [4:0] CHECK_POS    = 5'd9;
    localparam logic [4:0] YEAR_POS     = 5'd10;
    localparam logic [4:0] SERIAL_FIRST = 5'd12;
    localparam logic [4:0] POS_SAT      = 5'd18;
    localparam logic [4:0] RUN_MAX      = 5'd31;
    localparam logic [3:0] MOD_BASE     = 4'd11;

    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_1 = 8'h31;
    localparam logic [7:0] CH_9 = 8'h39;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_J = 8'h4A;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_Q = 8'h51;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_U = 8'h55;
    localparam logic [7:0] CH_X = 8'h58;
    localparam logic [7:0] CH_Z = 8'h5A;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_REPEAT = 2'd0;
    localparam logic [1:0] REG_MAX_STEP   = 2'd1;

    // fail reason codes
    localparam logic [2:0] RSN_NONE    = 3'd0;
    localparam logic [2:0] RSN_LENGTH  = 3'd1;
    localparam logic [2:0] RSN_CHAR    = 3'd2;
    localparam logic [2:0] RSN_CHECK   = 3'd3;
    localparam logic [2:0] RSN_REGION  = 3'd4;
    localparam logic [2:0] RSN_YEAR    = 3'd5;
    localparam logic [2:0] RSN_PATTERN = 3'd6;

    // Weighted sum is only ever needed mod 11, and never wraps, so the
    // residue alone is carried.
    typedef struct packed {
        logic [4:0] pos_count;
        logic [3:0] residue;
        logic [7:0] check_char;
        logic [7:0] prev_char;
        logic [4:0] repeat_run;
        logic [4:0] step_run;
        logic       char_error;
        logic       first_is_zero;
        logic       year_error;
        logic       serial_needs_digits;
        logic       serial_nondigit;
        logic       all_digits;
        logic       pattern_error;
    } scan_state_t;

    localparam scan_state_t SCAN_CLEAR = '{
        pos_count:           5'd0,
        residue:             4'd0,
        check_char:          8'd0,
        prev_char:           8'd0,
        repeat_run:          5'd1,
        step_run:            5'd0,
        char_error:          1'b0,
        first_is_zero:       1'b0,
        year_error:          1'b0,
        serial_needs_digits: 1'b0,
        serial_nondigit:     1'b0,
        all_digits:          1'b1,
        pattern_error:       1'b0
    };

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    function automatic logic is_vin_char(input logic [7:0] c);
        logic upper;
        upper = c inside {[CH_A:CH_Z]};
        return is_digit(c) || (upper && c != CH_I && c != CH_O && c != CH_Q);
    endfunction

    function automatic logic is_year_code(input logic [7:0] c);
        logic digit_ok;
        logic letter_ok;
        digit_ok  = c inside {[CH_1:CH_9]};
        letter_ok = is_vin_char(c) && !is_digit(c) && c != CH_U && c != CH_Z;
        return digit_ok || letter_ok;
    endfunction

    function automatic logic [3:0] translit(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (is_digit(c)) begin
            v = 4'(c - CH_0);
        end else if (c inside {[CH_A:CH_H]}) begin
            v = 4'(c - CH_A + 8'd1);
        end else if (c == CH_J) begin
            v = 4'd1;
        end else if (c inside {[CH_K:CH_N]}) begin
            v = 4'(c - CH_K + 8'd2);
        end else if (c == CH_P) begin
            v = 4'd7;
        end else if (c == CH_R) begin
            v = 4'd9;
        end else if (c inside {[CH_S:CH_Z]}) begin
            v = 4'(c - CH_S + 8'd2);
        end
        return v;
    endfunction

    function automatic logic [3:0] weight_of(input logic [4:0] pos);
        logic [3:0] w;
        case (pos)
            5'd1:    w = 4'd8;
            5'd2:    w = 4'd7;
            5'd3:    w = 4'd6;
            5'd4:    w = 4'd5;
            5'd5:    w = 4'd4;
            5'd6:    w = 4'd3;
            5'd7:    w = 4'd2;
            5'd8:    w = 4'd10;
            5'd10:   w = 4'd9;
            5'd11:   w = 4'd8;
            5'd12:   w = 4'd7;
            5'd13:   w = 4'd6;
            5'd14:   w = 4'd5;
            5'd15:   w = 4'd4;
            5'd16:   w = 4'd3;
            5'd17:   w = 4'd2;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    // x mod 11 for x < 128: reciprocal estimate (93/1024) is at most one low
    function automatic logic [3:0] mod11(input logic [6:0] x);
        logic [13:0] p;
        logic [3:0]  q;
        logic [6:0]  r;
        p = 14'(x) * 14'd93;
        q = p[13:10];
        r = 7'(x - 7'(q) * 7'(MOD_BASE));
        if (r >= 7'(MOD_BASE)) begin
            r = 7'(r - 7'(MOD_BASE));
        end
        return r[3:0];
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/vin_stream_validator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vin_stream_validator
// Streaming VIN check: one byte per transaction in, one verdict per candidate.
//
// Input channel s_*: one byte of the candidate per transaction, s_is_last
// set on its final byte. Output channel m_*: one transaction per candidate,
// issued for the last byte only, with m_vin_valid and m_fail_reason.
// Config channel cfg_*: index 0 max_repeat_run, index 1 max_step_pairs;
// other indexes are ignored. cfg_ready is always high; write only when idle.
// The last byte is taken into the input register, then passes the scan and
// verdict logic into the output register, which presents the verdict.
// Throughput: one byte per cycle while the verdict channel is not stalled.
// A stalled m_ready holds the verdict; s_ready then drops once the input
// register is also occupied, and the pipe resumes without loss.
// Reset clears all candidate state and loads the register defaults (4, 5).
// Candidate state is cleared after each verdict.
// ----------------------------------------------------------------------------
module vin_stream_validator (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_code,
    input  wire logic       s_is_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_vin_valid,
    output logic [2:0]      m_fail_reason,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [4:0] cfg_data
);
    import vsv_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    logic        m_valid_reg;
    logic        m_vin_valid_reg;
    logic [2:0]  m_fail_reason_reg;
    logic [4:0]  max_repeat_reg;
    logic [4:0]  max_step_reg;
    logic        advance;
    logic        verdict_valid;
    logic [2:0]  verdict_reason;
    scan_state_t state_upd;

    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_repeat_reg <= 5'd4;
            max_step_reg   <= 5'd5;
        end else if (cfg_valid) begin
            if (cfg_index == REG_MAX_REPEAT) begin
                max_repeat_reg <= cfg_data;
            end else if (cfg_index == REG_MAX_STEP) begin
                max_step_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_is_last;
        end
    end

    vsv_scan u_scan (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (in_valid_reg && advance),
        .char_code      (in_char_reg),
        .is_last        (in_last_reg),
        .max_repeat_run (max_repeat_reg),
        .max_step_pairs (max_step_reg),
        .state_upd      (state_upd)
    );

    vsv_verdict u_verdict (
        .state_upd   (state_upd),
        .vin_valid   (verdict_valid),
        .fail_reason (verdict_reason)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg && in_last_reg) begin
            m_vin_valid_reg   <= verdict_valid;
            m_fail_reason_reg <= verdict_reason;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_vin_valid   = m_vin_valid_reg;
    assign m_fail_reason = m_fail_reason_reg;

endmodule
`default_nettype wire

// File: hw/rtl/vsv_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vsv_scan
// Per-byte scanner: holds the running candidate state and updates it.
// ----------------------------------------------------------------------------
module vsv_scan (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step_en,
    input  wire logic [7:0]           char_code,
    input  wire logic                 is_last,
    input  wire logic [4:0]           max_repeat_run,
    input  wire logic [4:0]           max_step_pairs,
    output vsv_pkg::scan_state_t      state_upd
);
    import vsv_pkg::*;

    scan_state_t state_reg;
    scan_state_t state_next;
    logic [4:0]  pos;
    logic [6:0]  prod;
    logic [4:0]  rep_inc;
    logic [4:0]  step_inc;
    logic        step_pair;

    assign pos = (state_reg.pos_count < POS_SAT) ? 5'(state_reg.pos_count + 5'd1)
                                                 : state_reg.pos_count;
    assign prod     = 7'(translit(char_code) * weight_of(pos));
    assign rep_inc  = (state_reg.repeat_run < RUN_MAX) ? 5'(state_reg.repeat_run + 5'd1)
                                                       : state_reg.repeat_run;
    assign step_inc = (state_reg.step_run < RUN_MAX) ? 5'(state_reg.step_run + 5'd1)
                                                     : state_reg.step_run;
    // compared one bit wider so 0x00 and 0xFF do not count as a step
    assign step_pair = ({1'b0, char_code} == 9'({1'b0, state_reg.prev_char} + 9'd1))
                    || ({1'b0, state_reg.prev_char} == 9'({1'b0, char_code} + 9'd1));

    always_comb begin
        state_upd           = state_reg;
        state_upd.pos_count = pos;
        if (pos <= VIN_LEN) begin
            if (!is_vin_char(char_code)) begin
                state_upd.char_error = 1'b1;
            end
            if (pos != CHECK_POS) begin
                state_upd.residue = mod11(7'(state_reg.residue) + prod);
            end else begin
                state_upd.check_char = char_code;
            end
            if (pos == 5'd1 && char_code == CH_0) begin
                state_upd.first_is_zero = 1'b1;
            end
            if (pos == YEAR_POS) begin
                if (!is_year_code(char_code)) begin
                    state_upd.year_error = 1'b1;
                end
                state_upd.serial_needs_digits = char_code inside {[CH_1:CH_9]};
            end
            if (pos >= SERIAL_FIRST && !is_digit(char_code)) begin
                state_upd.serial_nondigit = 1'b1;
            end
            if (!is_digit(char_code)) begin
                state_upd.all_digits = 1'b0;
            end
            if (pos >= 5'd2) begin
                if (char_code == state_reg.prev_char) begin
                    state_upd.repeat_run = rep_inc;
                    if (rep_inc > max_repeat_run) begin
                        state_upd.pattern_error = 1'b1;
                    end
                end else begin
                    state_upd.repeat_run = 5'd1;
                end
                if (step_pair) begin
                    state_upd.step_run = step_inc;
                    if (step_inc > max_step_pairs) begin
                        state_upd.pattern_error = 1'b1;
                    end
                end else begin
                    state_upd.step_run = 5'd0;
                end
            end
            state_upd.prev_char = char_code;
        end
    end

    assign state_next = is_last ? SCAN_CLEAR : state_upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_CLEAR;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/vsv_verdict.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vsv_verdict
// Priority encoder of the final checks on the updated candidate state.
// ----------------------------------------------------------------------------
module vsv_verdict (
    input  wire vsv_pkg::scan_state_t state_upd,
    output logic                      vin_valid,
    output logic [2:0]                fail_reason
);
    import vsv_pkg::*;

    logic [7:0] expect_char;

    assign expect_char = (state_upd.residue == 4'd10) ? CH_X
                                                      : 8'(CH_0 + 8'(state_upd.residue));

    always_comb begin
        if (state_upd.pos_count != VIN_LEN) begin
            fail_reason = RSN_LENGTH;
        end else if (state_upd.char_error) begin
            fail_reason = RSN_CHAR;
        end else if (state_upd.check_char != expect_char) begin
            fail_reason = RSN_CHECK;
        end else if (state_upd.first_is_zero) begin
            fail_reason = RSN_REGION;
        end else if (state_upd.year_error
                     || (state_upd.serial_needs_digits && state_upd.serial_nondigit)) begin
            fail_reason = RSN_YEAR;
        end else if (state_upd.all_digits || state_upd.pattern_error) begin
            fail_reason = RSN_PATTERN;
        end else begin
            fail_reason = RSN_NONE;
        end
    end

    assign vin_valid = (fail_reason == RSN_NONE);

endmodule
`default_nettype wire

// File: bench/vin_stream_validator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vin_stream_validator_test
// Self-checking bench for the streaming VIN validator. Candidates are sent a
// byte at a time with random gaps and a randomly stalled verdict channel. A
// scoreboard class tracks the scan state, predicts each verdict and compares
// it with the block's output. The limit registers are changed between
// phases, only once the block has gone quiet.
// ----------------------------------------------------------------------------
module vin_stream_validator_test;
    import vsv_pkg::*;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         IDLE_CYCLES  = 6;
    localparam int         N_PHASES     = 7;
    localparam int         PHASE_BYTES  = 65;
    localparam int         PHASE_CANDS  = 4;
    localparam logic [1:0] REG_SPARE_2  = 2'd2;
    localparam logic [1:0] REG_SPARE_3  = 2'd3;

    typedef struct packed {
        logic       ok;
        logic [2:0] reason;
    } verdict_t;

    // Mirrors the scan state of one candidate and predicts its verdict.
    class vin_scoreboard;
        logic [4:0] max_rep;
        logic [4:0] max_step;
        logic [4:0] pos_count;
        logic [9:0] wsum;
        logic [7:0] chk;
        logic [7:0] prev;
        logic [4:0] rep;
        logic [4:0] stp;
        logic       char_err;
        logic       zero_first;
        logic       year_err;
        logic       serial_digits_req;
        logic       serial_letter;
        logic       only_digits;
        logic       pat_err;
        logic [3:0] weights [17];
        verdict_t   pending_verdicts [$];
        int         errors;

        function new();
            weights = '{4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd10, 4'd0,
                        4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2};
            max_rep  = 5'd4;
            max_step = 5'd5;
            errors   = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            pos_count = '0; wsum = '0; chk = '0; prev = '0;
            rep = 5'd1; stp = '0;
            char_err = 1'b0; zero_first = 1'b0; year_err = 1'b0;
            serial_digits_req = 1'b0; serial_letter = 1'b0;
            only_digits = 1'b1; pat_err = 1'b0;
        endfunction

        function logic digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function logic vin_char(logic [7:0] c);
            if (digit(c)) return 1'b1;
            if (c < "A" || c > "Z") return 1'b0;
            return c != "I" && c != "O" && c != "Q";
        endfunction

        function logic year_code(logic [7:0] c);
            if (c >= "1" && c <= "9") return 1'b1;
            if (!vin_char(c) || digit(c)) return 1'b0;
            return c != "U" && c != "Z";
        endfunction

        function logic [3:0] char_value(logic [7:0] c);
            if (digit(c)) return 4'(c - "0");
            if (c >= "A" && c <= "H") return 4'(c - "A" + 8'd1);
            if (c == "J") return 4'd1;
            if (c >= "K" && c <= "N") return 4'(c - "K" + 8'd2);
            if (c == "P") return 4'd7;
            if (c == "R") return 4'd9;
            if (c >= "S" && c <= "Z") return 4'(c - "S" + 8'd2);
            return 4'd0;
        endfunction

        function logic [3:0] weight_at(int pos);
            return weights[pos - 1];
        endfunction

        function void set_reg(logic [1:0] idx, logic [4:0] val);
            if (idx == REG_MAX_REPEAT) max_rep = val;
            else if (idx == REG_MAX_STEP) max_step = val;
        endfunction

        function void fail_note(string msg);
            errors++;
            if (errors <= 10) $display("[%0t] %s", $realtime, msg);
        endfunction

        // one accepted input transaction
        function void take_byte(logic [7:0] c, logic last);
            logic [7:0] diff;
            logic [9:0] resid;
            logic [7:0] want;
            verdict_t   v;
            if (pos_count < 5'd18) pos_count++;
            if (pos_count <= 5'd17) begin
                if (!vin_char(c)) char_err = 1'b1;
                if (pos_count != 5'd9) begin
                    wsum = 10'(wsum + 10'(char_value(c)) * 10'(weight_at(pos_count)));
                end else begin
                    chk = c;
                end
                if (pos_count == 5'd1 && c == "0") zero_first = 1'b1;
                if (pos_count == 5'd10) begin
                    if (!year_code(c)) year_err = 1'b1;
                    serial_digits_req = c >= "1" && c <= "9";
                end
                if (pos_count >= 5'd12 && !digit(c)) serial_letter = 1'b1;
                if (!digit(c)) only_digits = 1'b0;
                if (pos_count >= 5'd2) begin
                    diff = (c > prev) ? 8'(c - prev) : 8'(prev - c);
                    if (c == prev) begin
                        if (rep < 5'd31) rep++;
                        if (rep > max_rep) pat_err = 1'b1;
                    end else begin
                        rep = 5'd1;
                    end
                    if (diff == 8'd1) begin
                        if (stp < 5'd31) stp++;
                        if (stp > max_step) pat_err = 1'b1;
                    end else begin
                        stp = '0;
                    end
                end
                prev = c;
            end
            if (last) begin
                resid = wsum % 10'd11;
                want  = (resid == 10'd10) ? 8'("X") : 8'(8'("0") + resid[7:0]);
                if (pos_count != 5'd17)                      v.reason = RSN_LENGTH;
                else if (char_err)                          v.reason = RSN_CHAR;
                else if (chk != want)                       v.reason = RSN_CHECK;
                else if (zero_first)                        v.reason = RSN_REGION;
                else if (year_err || (serial_digits_req && serial_letter))
                                                            v.reason = RSN_YEAR;
                else if (only_digits || pat_err)            v.reason = RSN_PATTERN;
                else                                        v.reason = RSN_NONE;
                v.ok = (v.reason == RSN_NONE);
                pending_verdicts.push_back(v);
                clear_scan();
            end
        endfunction

        function void check_verdict(logic got_ok, logic [2:0] got_reason);
            verdict_t v;
            if (pending_verdicts.size() == 0) begin
                fail_note($sformatf("unexpected verdict valid=%0d reason=%0d",
                                    got_ok, got_reason));
                return;
            end
            v = pending_verdicts.pop_front();
            if (got_ok !== v.ok || got_reason !== v.reason) begin
                fail_note($sformatf("verdict mismatch: expected valid=%0d reason=%0d, got valid=%0d reason=%0d",
                                    v.ok, v.reason, got_ok, got_reason));
            end
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_code   = 8'd0;
    logic       s_is_last     = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic       m_vin_valid;
    logic [2:0] m_fail_reason;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index     = 2'd0;
    logic [4:0] cfg_data      = 5'd0;

    vin_scoreboard sb = new();
    logic [7:0]    cand [$];
    int            cycle_count = 0;
    int            ready_hold  = 0;
    logic          ready_level = 1'b1;

    string VIN_ALPHA  = "0123456789ABCDEFGHJKLMNPRSTUVWXYZ";
    string YEAR_ALPHA = "123456789ABCDEFGHJKLMNPRSTVWXY";
    string SAMPLE_VIN = "1M8GDM9AXKP042788";

    logic [4:0] repeat_plan [N_PHASES] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd4, 5'd9};
    logic [4:0] step_plan   [N_PHASES] = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd3, 5'd5, 5'd12};

    vin_stream_validator DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_vin_valid   (m_vin_valid),
        .m_fail_reason (m_fail_reason),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // verdict channel back-pressure: mostly ready, short and occasional long stalls
    always @(posedge aclk) begin
        int r;
        if (ready_hold == 0) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                ready_level = 1'b1;
                ready_hold  = $urandom_range(1, 20);
            end else if (r < 92) begin
                ready_level = 1'b0;
                ready_hold  = $urandom_range(1, 3);
            end else begin
                ready_level = 1'b0;
                ready_hold  = $urandom_range(8, 40);
            end
        end else begin
            ready_hold--;
        end
        m_ready <= ready_level;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_verdict(m_vin_valid, m_fail_reason);
    end

    function logic [7:0] random_vin_char();
        return VIN_ALPHA[$urandom_range(0, 32)];
    endfunction

    function void load_str(string s);
        cand.delete();
        for (int i = 0; i < s.len(); i++) cand.push_back(s[i]);
    endfunction

    // rewrite position 9 so the weighted sum agrees with it
    function void fix_check();
        int sum;
        int resid;
        sum = 0;
        if (cand.size() < 17) return;
        for (int i = 0; i < 17; i++) begin
            if (i != 8) sum += sb.char_value(cand[i]) * sb.weight_at(i + 1);
        end
        resid = sum % 11;
        cand[8] = (resid == 10) ? 8'("X") : 8'(8'("0") + 8'(resid));
    endfunction

    function void build_wellformed();
        logic year_digit;
        cand.delete();
        cand.push_back(VIN_ALPHA[$urandom_range(1, 32)]);
        for (int i = 1; i < 9; i++) cand.push_back(random_vin_char());
        cand.push_back(YEAR_ALPHA[$urandom_range(0, 29)]);
        cand.push_back(random_vin_char());
        year_digit = sb.digit(cand[9]);
        for (int i = 11; i < 17; i++) begin
            if (year_digit || $urandom_range(0, 1) == 0)
                cand.push_back(8'(8'("0") + 8'($urandom_range(0, 9))));
            else
                cand.push_back(random_vin_char());
        end
        fix_check();
    endfunction

    function void build_random_candidate();
        int         kind;
        int         start;
        int         len;
        int         stop;
        logic [7:0] ch;
        logic       down;
        build_wellformed();
        kind = $urandom_range(0, 99);
        if (kind < 48) begin
            // left well-formed
        end else if (kind < 54) begin
            cand[$urandom_range(0, 16)] = 8'($urandom_range(0, 255));
        end else if (kind < 58) begin
            cand[$urandom_range(0, 16)] = 8'(8'("a") + 8'($urandom_range(0, 25)));
            fix_check();
        end else if (kind < 62) begin
            cand[8] = random_vin_char();
        end else if (kind < 66) begin
            cand[0] = "0";
            fix_check();
        end else if (kind < 70) begin
            case ($urandom_range(0, 3))
                0:       cand[9] = "U";
                1:       cand[9] = "Z";
                2:       cand[9] = "0";
                default: cand[9] = random_vin_char();
            endcase
            fix_check();
        end else if (kind < 74) begin
            cand[9] = 8'(8'("1") + 8'($urandom_range(0, 8)));
            cand[$urandom_range(11, 16)] = VIN_ALPHA[$urandom_range(10, 32)];
            fix_check();
        end else if (kind < 78) begin
            for (int i = 0; i < 17; i++) cand[i] = 8'(8'("0") + 8'($urandom_range(0, 9)));
            cand[0] = 8'(8'("1") + 8'($urandom_range(0, 8)));
            cand[9] = 8'(8'("1") + 8'($urandom_range(0, 8)));
            fix_check();
        end else if (kind < 84) begin
            start = $urandom_range(0, 15);
            len   = $urandom_range(2, 17);
            stop  = (start + len > 17) ? 17 : start + len;
            ch    = random_vin_char();
            for (int i = start; i < stop; i++) cand[i] = ch;
            fix_check();
        end else if (kind < 90) begin
            start = $urandom_range(0, 15);
            len   = $urandom_range(2, 17);
            stop  = (start + len > 17) ? 17 : start + len;
            down  = $urandom_range(0, 1);
            ch    = down ? VIN_ALPHA[$urandom_range(17, 32)] : VIN_ALPHA[$urandom_range(0, 16)];
            for (int i = start; i < stop; i++) begin
                cand[i] = down ? 8'(ch - 8'(i - start)) : 8'(ch + 8'(i - start));
            end
            if ($urandom_range(0, 1) == 0) fix_check();
        end else if (kind < 95) begin
            if ($urandom_range(0, 1) == 0) begin
                len = $urandom_range(1, 16);
                while (cand.size() > len) void'(cand.pop_back());
            end else begin
                len = $urandom_range(1, 5);
                repeat (len) cand.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            cand.delete();
            len = $urandom_range(1, 24);
            repeat (len) cand.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic last, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        s_is_last   <= last;
        do @(posedge aclk); while (!s_ready);
        sb.take_byte(c, last);
    endtask

    task automatic send_candidate();
        logic burst;
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < cand.size(); i++) begin
            send_byte(cand[i], i == cand.size() - 1, burst ? 0 : pick_gap());
        end
    endtask

    // leaves cfg_valid high so back-to-back writes need no toggle in one step
    task automatic cfg_write(input logic [1:0] idx, input logic [4:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_directed();
        load_str(SAMPLE_VIN);                             send_candidate();
        // byte past the seventeenth, all ones
        load_str(SAMPLE_VIN); cand.push_back(8'hFF);      send_candidate();
        cand.delete(); cand.push_back(8'h00);             send_candidate();
        load_str(SAMPLE_VIN); cand[4] = 8'h00;            send_candidate();
        load_str(SAMPLE_VIN); cand[2] = "a";              send_candidate();
        load_str(SAMPLE_VIN); cand[3] = "I"; cand[6] = "O"; cand[10] = "Q";
        send_candidate();
        load_str(SAMPLE_VIN); cand[8] = "0";              send_candidate();
        load_str(SAMPLE_VIN); cand[0] = "0"; fix_check(); send_candidate();
        load_str(SAMPLE_VIN); cand[9] = "U"; fix_check(); send_candidate();
        load_str(SAMPLE_VIN); cand[9] = "5"; cand[11] = "A"; fix_check();
        send_candidate();
        load_str("11234567091234567"); fix_check();       send_candidate();
        load_str("1AAAAAM8XKP042788"); fix_check();       send_candidate();
        load_str("1ABCDEFGXKP042788"); fix_check();       send_candidate();
        load_str("1M8GDM9AXK6543210"); fix_check();       send_candidate();
    endtask

    initial begin
        int phase_bytes;
        int phase_cands;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            if (p < N_PHASES - 2) begin
                cfg_write(REG_MAX_REPEAT, repeat_plan[p]);
                cfg_write(REG_MAX_STEP, step_plan[p]);
            end else begin
                cfg_write(REG_MAX_REPEAT, 5'($urandom_range(1, 16)));
                cfg_write(REG_MAX_STEP, 5'($urandom_range(1, 16)));
            end
            // spare indexes must leave both limits alone
            cfg_write(REG_SPARE_2, 5'($urandom_range(0, 31)));
            cfg_write(REG_SPARE_3, 5'($urandom_range(0, 31)));
            cfg_valid <= 1'b0;
            phase_bytes = 0;
            phase_cands = 0;
            while (phase_bytes < PHASE_BYTES || phase_cands < PHASE_CANDS) begin
                build_random_candidate();
                phase_bytes += cand.size();
                phase_cands++;
                send_candidate();
            end
        end
        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/vsv_pkg.sv
hw/rtl/vsv_scan.sv
hw/rtl/vsv_verdict.sv
hw/rtl/vin_stream_validator.sv
bench/vin_stream_validator_test.sv
